FILE: design/ibmr_pkg.sv
// ----------------------------------------------------------------------------
// ibmr_pkg
// Shared types and constants for the binary message receiver: protocol
// codes, parse phases, capture state and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package ibmr_pkg;

	// Sync word, sent low byte first
	localparam logic [7:0]  SYNC_LO   = 8'hFF;
	localparam logic [7:0]  SYNC_HI   = 8'h81;
	localparam logic [15:0] SYNC_WORD = 16'h81FF;

	// Message identifiers
	localparam logic [15:0] ID_TIME_MARK = 16'd3;
	localparam logic [15:0] ID_NAV       = 16'd3501;
	localparam logic [15:0] ID_FLIGHT    = 16'd3512;

	// Payload lengths in words, checksum word included
	localparam logic [6:0] WORDS_TIME_MARK = 7'd63;
	localparam logic [6:0] WORDS_NAV       = 7'd23;
	localparam logic [6:0] WORDS_FLIGHT    = 7'd17;

	// Header byte indices: high byte of the id word, high byte of the last header word (checksum), first byte after sync
	localparam logic [6:0] HDR_ID_HI   = 7'd3;
	localparam logic [6:0] HDR_LAST_HI = 7'd9;
	localparam logic [6:0] HDR_FIRST   = 7'd2;

	// Time mark word positions
	localparam logic [5:0] TM_MODE_WORD   = 6'd38;
	localparam logic [5:0] TM_STATUS_WORD = 6'd39;
	localparam logic [5:0] TM_SATS_WORD   = 6'd40;
	localparam logic [5:0] TM_TRACK_FIRST = 6'd52;
	localparam logic [5:0] TM_TRACK_LAST  = 6'd60;
	localparam logic [2:0] TRACK_STATE    = 3'd5;
	localparam logic [5:0] FIELD_WORDS    = 6'd10;

	// Result codes
	localparam logic [1:0] KIND_TIME_MARK = 2'd0;
	localparam logic [1:0] KIND_NAV       = 2'd1;
	localparam logic [1:0] KIND_FLIGHT    = 2'd2;
	localparam logic [1:0] KIND_HEADER    = 2'd3;

	localparam logic [1:0] STAT_GOOD     = 2'd0;
	localparam logic [1:0] STAT_HDR_BAD  = 2'd1;
	localparam logic [1:0] STAT_PAY_BAD  = 2'd2;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_SYNC2,
		PH_HEADER,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic [4:0][31:0] fields;
		logic [2:0][15:0] words;   // status, satellites, mode
		logic [4:0]       track;
	} capture_t;

	typedef struct packed {
		logic [1:0]         msg_kind;
		logic [1:0]         frame_status;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic signed [63:0] time_value;
		logic               gps_valid;
		logic [15:0]        sat_count;
		logic [15:0]        nav_mode;
		logic [4:0]         tracking_mask;
	} result_t;

	// Payload word count for a message id, zero when unknown
	function automatic logic [6:0] words_for_id(input logic [15:0] id);
		logic [6:0] n;
		begin
			n = 7'd0;
			if (id == ID_TIME_MARK) n = WORDS_TIME_MARK;
			else if (id == ID_NAV) n = WORDS_NAV;
			else if (id == ID_FLIGHT) n = WORDS_FLIGHT;
			return n;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/ibmr_parser.sv
// ----------------------------------------------------------------------------
// ibmr_parser
// Frame parser: sync hunt, header capture and check, payload capture and
// checksum. Consumes one byte per step and raises a result on frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmr_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire logic             header_check_enable,
	output ibmr_pkg::result_t     res,
	output logic                  res_valid
);
	import ibmr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [6:0]  idx_q, idx_d;
	logic [7:0]  low_q, low_d;
	logic [15:0] hsum_q, hsum_d;
	logic [15:0] id_q, id_d;
	logic [15:0] psum_q, psum_d;
	capture_t    cap_q, cap_d;

	logic [15:0] word;
	logic [5:0]  k;
	logic [5:0]  k_off;
	logic [2:0]  field_sel;
	logic [2:0]  track_sel;
	logic [6:0]  nw;
	logic [1:0]  kind_of_id;

	assign word      = {rx_byte, low_q};
	assign k         = idx_q[6:1];
	assign k_off     = k - TM_TRACK_FIRST;
	assign track_sel = k_off[3:1];
	assign field_sel = k[3:1];
	assign nw        = words_for_id(id_q);
	assign kind_of_id = (id_q == ID_TIME_MARK) ? KIND_TIME_MARK :
		(id_q == ID_NAV) ? KIND_NAV : KIND_FLIGHT;

	// Build the result record from the captured fields
	function automatic result_t build(input logic [1:0] kind, input logic [1:0] stat,
			input capture_t c);
		result_t r;
		begin
			r = '0;
			r.msg_kind     = kind;
			r.frame_status = stat;
			if (stat == STAT_GOOD && kind != KIND_HEADER) begin
				if (kind == KIND_TIME_MARK) begin
					r.gps_valid     = c.words[0][0];
					r.sat_count     = c.words[1];
					r.nav_mode      = c.words[2];
					r.tracking_mask = c.track;
				end else begin
					r.value_a = c.fields[2];
					r.value_b = c.fields[3];
					r.value_c = c.fields[4];
					if (kind == KIND_FLIGHT) r.time_value = {c.fields[0], c.fields[1]};
				end
			end
			return r;
		end
	endfunction

	// Next state and result
	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		low_d     = low_q;
		hsum_d    = hsum_q;
		id_d      = id_q;
		psum_d    = psum_q;
		cap_d     = cap_q;
		res       = '0;
		res_valid = 1'b0;
		if (step) begin
			case (phase_q)
				PH_SYNC2: begin
					if (rx_byte == SYNC_HI) begin
						phase_d = PH_HEADER;
						idx_d   = HDR_FIRST;
						hsum_d  = SYNC_WORD;
					end else if (rx_byte != SYNC_LO) begin
						phase_d = PH_HUNT;
					end
				end
				PH_HEADER: begin
					if (!idx_q[0]) begin
						low_d = rx_byte;
						idx_d = idx_q + 7'd1;
					end else begin
						if (idx_q == HDR_ID_HI) id_d = word;
						if (idx_q < HDR_LAST_HI) begin
							hsum_d = hsum_q + word;
							idx_d  = idx_q + 7'd1;
						end else begin
							phase_d = PH_HUNT;
							idx_d   = 7'd0;
							if ((hsum_q + word) != 16'd0 && header_check_enable) begin
								res       = build(KIND_HEADER, STAT_HDR_BAD, cap_q);
								res_valid = 1'b1;
							end else if (nw == 7'd0) begin
								res       = build(KIND_HEADER, STAT_GOOD, cap_q);
								res_valid = 1'b1;
							end else begin
								cap_d   = '0;
								psum_d  = 16'd0;
								phase_d = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					if (nw == 7'd0) begin
						phase_d = PH_HUNT;
						idx_d   = 7'd0;
					end else if (!idx_q[0]) begin
						low_d = rx_byte;
						idx_d = idx_q + 7'd1;
					end else if (({1'b0, k} + 7'd1) < nw) begin
						psum_d = psum_q + word;
						idx_d  = idx_q + 7'd1;
						// capture the word into its field
						if (id_q == ID_TIME_MARK) begin
							if (k == TM_MODE_WORD) cap_d.words[2] = word;
							else if (k == TM_STATUS_WORD) cap_d.words[0] = word;
							else if (k == TM_SATS_WORD) cap_d.words[1] = word;
							else if (k >= TM_TRACK_FIRST && k <= TM_TRACK_LAST && !k[0]) begin
								if (word[7:5] == TRACK_STATE) cap_d.track[track_sel] = 1'b1;
							end
						end else if (k < FIELD_WORDS) begin
							if (k[0]) cap_d.fields[field_sel][31:16] =
								cap_q.fields[field_sel][31:16] | word;
							else cap_d.fields[field_sel][15:0] =
								cap_q.fields[field_sel][15:0] | word;
						end
					end else begin
						phase_d   = PH_HUNT;
						idx_d     = 7'd0;
						res       = build(kind_of_id,
							((psum_q + word) == 16'd0) ? STAT_GOOD : STAT_PAY_BAD, cap_q);
						res_valid = 1'b1;
					end
				end
				default: begin
					phase_d = (rx_byte == SYNC_LO) ? PH_SYNC2 : PH_HUNT;
				end
			endcase
		end
	end

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= 7'd0;
			low_q   <= 8'd0;
			hsum_q  <= 16'd0;
			id_q    <= 16'd0;
			psum_q  <= 16'd0;
			cap_q   <= '0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			low_q   <= low_d;
			hsum_q  <= hsum_d;
			id_q    <= id_d;
			psum_q  <= psum_d;
			cap_q   <= cap_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/ibmr_out_reg.sv
// ----------------------------------------------------------------------------
// ibmr_out_reg
// Result register: holds one finished result until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire ibmr_pkg::result_t res_in,
	input  wire logic              out_stall,
	output logic                   out_free,
	output logic                   out_valid,
	output ibmr_pkg::result_t      res_out
);
	import ibmr_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Slot is free when empty or its transaction completes this cycle
	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Capture payload on load
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

`default_nettype wire

FILE: design/ins_binary_message_receiver_top.sv
// ----------------------------------------------------------------------------
// ins_binary_message_receiver_top
// Binary message deframer: byte input register, frame parser and result
// register, plus the header check enable register.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   rx_byte
//   out       out_valid / out_stall msg_kind .. tracking_mask
//   cfg       cfg_valid / cfg_ready cfg_header_check_enable
//
// One byte per cycle sustained while the result register is free; a byte is
// held in the input byte register, then parsed, and the result is registered.
// Reset puts the parser into the sync hunt with the header check enabled.
// A held result stalls the parser, which stalls the input once its byte
// register is full; configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ins_binary_message_receiver_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              msg_kind,
	output logic [1:0]              frame_status,
	output logic signed [31:0]      value_a,
	output logic signed [31:0]      value_b,
	output logic signed [31:0]      value_c,
	output logic signed [63:0]      time_value,
	output logic                    gps_valid,
	output logic [15:0]             sat_count,
	output logic [15:0]             nav_mode,
	output logic [4:0]              tracking_mask,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_header_check_enable
);
	import ibmr_pkg::*;

	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       hce_q;
	logic       advance;
	logic       out_free;
	logic       res_valid;
	result_t    res;
	result_t    res_out;

	assign cfg_ready = 1'b1;
	assign advance   = byte_valid_s1 && out_free;
	assign in_stall  = byte_valid_s1 && !advance;

	// Hold header check enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hce_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			hce_q <= cfg_header_check_enable;
		end
	end

	// Input byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	ibmr_parser u_parser (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (advance),
		.rx_byte             (byte_s1),
		.header_check_enable (hce_q),
		.res                 (res),
		.res_valid           (res_valid)
	);

	ibmr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res_in    (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	// Drive result fields
	assign msg_kind      = res_out.msg_kind;
	assign frame_status  = res_out.frame_status;
	assign value_a       = res_out.value_a;
	assign value_b       = res_out.value_b;
	assign value_c       = res_out.value_c;
	assign time_value    = res_out.time_value;
	assign gps_valid     = res_out.gps_valid;
	assign sat_count     = res_out.sat_count;
	assign nav_mode      = res_out.nav_mode;
	assign tracking_mask = res_out.tracking_mask;

endmodule

`default_nettype wire
